// ===== rtl/bgce_pkg.sv =====
// ----------------------------------------------------------------------------
// Bar graph emitter package
// Shared widths, register indexes, reset values and interface types.
// ----------------------------------------------------------------------------
package bgce_pkg;

   localparam int MAX_COLS_DEF = 40;

   localparam int LEVEL_W   = 16;
   localparam int FS_W      = 16;
   localparam int NCOLS_W   = 6;
   localparam int COL_W     = 6;
   localparam int ROW_W     = 2;
   localparam int CODE_W    = 8;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 16;

   localparam int SUBSTEPS = 5;
   localparam logic [CODE_W-1:0] SPACE_CODE = 8'd32;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_NUM_COLS    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_START_X     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_START_Y     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_FULL_SCALE  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_FILLED_CODE = 3'd4;

   // Reset values
   localparam logic [NCOLS_W-1:0] NUM_COLS_RST    = 6'd16;
   localparam logic [COL_W-1:0]   START_X_RST     = 6'd0;
   localparam logic [ROW_W-1:0]   START_Y_RST     = 2'd0;
   localparam logic [FS_W-1:0]    FULL_SCALE_RST  = 16'd100;
   localparam logic [CODE_W-1:0]  FILLED_CODE_RST = 8'd0;

   typedef struct packed {
      logic busy;
      logic done;
   } scl_status_type;

   typedef struct packed {
      logic [COL_W-1:0]  start_x;
      logic [ROW_W-1:0]  start_y;
      logic [CODE_W-1:0] filled_code;
   } disp_cfg_type;

endpackage

// ===== rtl/bgce_scaler.sv =====
// ----------------------------------------------------------------------------
// Bar graph scaler
// Bit-serial shift-add multiply of level by cols*5, then a restoring
// divide by full scale, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bgce_scaler #(
   parameter int KW = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [bgce_pkg::LEVEL_W-1:0] level,
   input  logic [KW-1:0]                k,
   input  logic [bgce_pkg::FS_W-1:0]    full_scale,
   output bgce_pkg::scl_status_type     status,
   output logic [KW-1:0]                q
);
   import bgce_pkg::*;

   localparam int PW   = LEVEL_W + KW;
   localparam int CNTW = $clog2(PW);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_MUL  = 2'd1;
   localparam logic [1:0] S_DIV  = 2'd2;

   logic [1:0]         state_ff, state_in;
   logic [CNTW-1:0]    cnt_ff, cnt_in;
   logic [LEVEL_W-1:0] lvl_ff, lvl_in;
   logic [KW-1:0]      k_ff, k_in;
   logic [FS_W-1:0]    fs_ff, fs_in;
   logic               fz_ff, fz_in;
   logic [PW-1:0]      dq_ff, dq_in;
   logic [FS_W-1:0]    rem_ff, rem_in;
   logic               done_ff, done_in;

   logic [FS_W:0] trial;
   logic [FS_W:0] diff;
   logic          fits;
   logic [PW-1:0] addend;

   always_comb begin
      trial  = {rem_ff, dq_ff[PW-1]};
      diff   = trial - {1'b0, fs_ff};
      fits   = trial >= {1'b0, fs_ff};
      addend = lvl_ff[LEVEL_W-1] ? PW'(k_ff) : '0;
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      lvl_in   = lvl_ff;
      k_in     = k_ff;
      fs_in    = fs_ff;
      fz_in    = fz_ff;
      dq_in    = dq_ff;
      rem_in   = rem_ff;
      done_in  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               lvl_in   = level;
               k_in     = k;
               fs_in    = full_scale;
               fz_in    = (full_scale == '0);
               dq_in    = '0;
               cnt_in   = CNTW'(LEVEL_W - 1);
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            // Level bits enter MSB first.
            dq_in  = {dq_ff[PW-2:0], 1'b0} + addend;
            lvl_in = {lvl_ff[LEVEL_W-2:0], 1'b0};
            if (cnt_ff == '0) begin
               cnt_in   = CNTW'(PW - 1);
               rem_in   = '0;
               state_in = S_DIV;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         S_DIV: begin
            // Dividend bits shift out the top while quotient bits enter below.
            rem_in = fits ? diff[FS_W-1:0] : trial[FS_W-1:0];
            dq_in  = {dq_ff[PW-2:0], fits};
            if (cnt_ff == '0) begin
               done_in  = 1'b1;
               state_in = S_IDLE;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      lvl_ff <= lvl_in;
      k_ff   <= k_in;
      fs_ff  <= fs_in;
      fz_ff  <= fz_in;
      dq_ff  <= dq_in;
      rem_ff <= rem_in;
   end

   assign status.busy = (state_ff != S_IDLE);
   assign status.done = done_ff;
   assign q = fz_ff ? '0 : dq_ff[KW-1:0];

endmodule

// ===== rtl/bgce_emitter.sv =====
// ----------------------------------------------------------------------------
// Bar graph code emitter
// Walks the scaled value down five sub-steps at a time and sends the cursor,
// filled, partial and space beats through a single output register.
// ----------------------------------------------------------------------------
module bgce_emitter #(
   parameter int KW    = 8,
   parameter int CELLW = 6
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        go,
   input  logic [KW-1:0]               q,
   input  bgce_pkg::disp_cfg_type      cfg,
   output logic                        busy,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_is_cursor,
   output logic [bgce_pkg::COL_W-1:0]  rsp_column,
   output logic [bgce_pkg::ROW_W-1:0]  rsp_row,
   output logic [bgce_pkg::CODE_W-1:0] rsp_char_code,
   output logic                        rsp_last
);
   import bgce_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_CURSOR = 3'd1;
   localparam logic [2:0] ST_FILL   = 3'd2;
   localparam logic [2:0] ST_PART   = 3'd3;
   localparam logic [2:0] ST_SPACE  = 3'd4;

   logic [2:0]       state_ff, state_in;
   logic [KW-1:0]    q_ff, q_in;
   logic [KW-1:0]    rem_ff, rem_in;
   logic [CELLW-1:0] cells_ff, cells_in;
   logic [CELLW-1:0] newcells_ff, newcells_in;
   logic [KW-1:0]    prev_scaled_ff, prev_scaled_in;
   logic [CELLW-1:0] prev_cells_ff, prev_cells_in;

   logic              valid_ff, valid_in;
   logic              cursor_ff, cursor_in;
   logic [COL_W-1:0]  column_ff, column_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [CODE_W-1:0] code_ff, code_in;
   logic              last_ff, last_in;

   logic             slot_free;
   logic             emit;
   logic [KW-1:0]    rem_n;
   logic [CELLW-1:0] cells_n;
   logic [2:0]       nxt;

   assign slot_free = !valid_ff || !rsp_stall;
   assign emit      = slot_free && (state_ff != ST_IDLE);

   // Remaining sub-steps and cell position after the beat of this state.
   always_comb begin
      rem_n   = rem_ff;
      cells_n = cells_ff;
      unique case (state_ff) inside
         ST_IDLE, ST_CURSOR: begin
            rem_n   = rem_ff;
            cells_n = cells_ff;
         end
         ST_FILL: begin
            rem_n   = rem_ff - KW'(SUBSTEPS);
            cells_n = cells_ff + 1'b1;
         end
         ST_PART, ST_SPACE: begin
            rem_n   = '0;
            cells_n = cells_ff + 1'b1;
         end
         default: begin
            rem_n   = rem_ff;
            cells_n = cells_ff;
         end
      endcase
      if (rem_n >= KW'(SUBSTEPS)) begin
         nxt = ST_FILL;
      end else if (rem_n != '0) begin
         nxt = ST_PART;
      end else if (cells_n < prev_cells_ff) begin
         nxt = ST_SPACE;
      end else begin
         nxt = ST_IDLE;
      end
   end

   always_comb begin
      state_in       = state_ff;
      q_in           = q_ff;
      rem_in         = rem_ff;
      cells_in       = cells_ff;
      newcells_in    = newcells_ff;
      prev_scaled_in = prev_scaled_ff;
      prev_cells_in  = prev_cells_ff;
      cursor_in      = cursor_ff;
      column_in      = column_ff;
      row_in         = row_ff;
      code_in        = code_ff;
      last_in        = last_ff;

      if (emit) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end

      if (state_ff == ST_IDLE) begin
         if (go && (q != prev_scaled_ff)) begin
            q_in     = q;
            rem_in   = q;
            cells_in = '0;
            state_in = ST_CURSOR;
         end
      end else if (emit) begin
         cursor_in = (state_ff == ST_CURSOR);
         column_in = (state_ff == ST_CURSOR) ? cfg.start_x : '0;
         row_in    = (state_ff == ST_CURSOR) ? cfg.start_y : '0;
         unique case (state_ff)
            ST_FILL:  code_in = cfg.filled_code;
            ST_PART:  code_in = CODE_W'(rem_ff[2:0]);
            ST_SPACE: code_in = SPACE_CODE;
            default:  code_in = '0;
         endcase
         last_in  = (nxt == ST_IDLE);
         rem_in   = rem_n;
         cells_in = cells_n;
         state_in = nxt;
         // The bar's own cell count is fixed once the content beats are done.
         if (state_ff != ST_SPACE && nxt != ST_FILL && nxt != ST_PART) begin
            newcells_in = cells_n;
         end
         if (nxt == ST_IDLE) begin
            prev_scaled_in = q_ff;
            prev_cells_in  = (state_ff == ST_SPACE) ? newcells_ff : cells_n;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         valid_ff       <= 1'b0;
         prev_scaled_ff <= '0;
         prev_cells_ff  <= '0;
      end else begin
         state_ff       <= state_in;
         valid_ff       <= valid_in;
         prev_scaled_ff <= prev_scaled_in;
         prev_cells_ff  <= prev_cells_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff        <= q_in;
      rem_ff      <= rem_in;
      cells_ff    <= cells_in;
      newcells_ff <= newcells_in;
      cursor_ff   <= cursor_in;
      column_ff   <= column_in;
      row_ff      <= row_in;
      code_ff     <= code_in;
      last_ff     <= last_in;
   end

   assign busy          = (state_ff != ST_IDLE);
   assign rsp_valid     = valid_ff;
   assign rsp_is_cursor = cursor_ff;
   assign rsp_column    = column_ff;
   assign rsp_row       = row_ff;
   assign rsp_char_code = code_ff;
   assign rsp_last      = last_ff;

endmodule

// ===== rtl/bar_graph_char_emitter.sv =====
// ----------------------------------------------------------------------------
// Bar graph character emitter
// Scales a level to a bar of character cells and emits display commands.
// ----------------------------------------------------------------------------
// Usage:
// The req channel takes one 16-bit level per beat. A level above full scale
// is taken and dropped. Otherwise the level is multiplied bit-serially by
// cols*5 and then divided by full scale one quotient bit a cycle, and the
// first rsp beat follows the divide. If the scaled value matches the last
// one drawn, no beats follow and the next req beat is taken once the
// scaler has finished. Otherwise the rsp channel carries one beat per cycle
// while rsp is not stalled: a set-cursor beat, the filled and partial
// cells, then spaces that clear the old bar; rsp_last marks the final
// beat. An item yields up to 41 beats. req_stall stays high while an item
// is in progress.
// A stall on rsp holds the output register and pauses the sequencer.
// The csr channel is always ready; registers are written by index and should
// only be written while the block is idle. Reset restores the register
// defaults and forgets the previously drawn bar.
// ----------------------------------------------------------------------------
module bar_graph_char_emitter #(
   parameter int MAX_COLS = bgce_pkg::MAX_COLS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [bgce_pkg::LEVEL_W-1:0]   req_level,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_is_cursor,
   output logic [bgce_pkg::COL_W-1:0]     rsp_column,
   output logic [bgce_pkg::ROW_W-1:0]     rsp_row,
   output logic [bgce_pkg::CODE_W-1:0]    rsp_char_code,
   output logic                           rsp_last,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [bgce_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bgce_pkg::CSR_DAT_W-1:0] csr_data
);
   import bgce_pkg::*;

   localparam int KW    = $clog2(MAX_COLS * SUBSTEPS + 1);
   localparam int CELLW = $clog2(MAX_COLS + 1);

   logic [NCOLS_W-1:0] num_cols_ff, num_cols_in;
   logic [COL_W-1:0]   start_x_ff, start_x_in;
   logic [ROW_W-1:0]   start_y_ff, start_y_in;
   logic [FS_W-1:0]    full_scale_ff, full_scale_in;
   logic [CODE_W-1:0]  filled_code_ff, filled_code_in;

   logic [NCOLS_W-1:0] cols_sat;
   logic [KW-1:0]      k;
   logic               req_fire;
   logic               start;
   logic               emit_busy;
   logic [KW-1:0]      q;
   scl_status_type     scl_status;
   disp_cfg_type       disp_cfg;

   assign csr_ready = 1'b1;

   always_comb begin
      num_cols_in    = num_cols_ff;
      start_x_in     = start_x_ff;
      start_y_in     = start_y_ff;
      full_scale_in  = full_scale_ff;
      filled_code_in = filled_code_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_NUM_COLS:    num_cols_in    = csr_data[NCOLS_W-1:0];
            REG_START_X:     start_x_in     = csr_data[COL_W-1:0];
            REG_START_Y:     start_y_in     = csr_data[ROW_W-1:0];
            REG_FULL_SCALE:  full_scale_in  = csr_data[FS_W-1:0];
            REG_FILLED_CODE: filled_code_in = csr_data[CODE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_cols_ff    <= NUM_COLS_RST;
         start_x_ff     <= START_X_RST;
         start_y_ff     <= START_Y_RST;
         full_scale_ff  <= FULL_SCALE_RST;
         filled_code_ff <= FILLED_CODE_RST;
      end else begin
         num_cols_ff    <= num_cols_in;
         start_x_ff     <= start_x_in;
         start_y_ff     <= start_y_in;
         full_scale_ff  <= full_scale_in;
         filled_code_ff <= filled_code_in;
      end
   end

   // Cell count saturates at MAX_COLS; cols*5 is formed as cols*4 + cols.
   assign cols_sat = (num_cols_ff > NCOLS_W'(MAX_COLS)) ? NCOLS_W'(MAX_COLS) : num_cols_ff;
   assign k        = KW'(cols_sat) + (KW'(cols_sat) << 2);

   assign req_stall = scl_status.busy || scl_status.done || emit_busy;
   assign req_fire  = req_valid && !req_stall;
   assign start     = req_fire && (req_level <= full_scale_ff);

   assign disp_cfg.start_x     = start_x_ff;
   assign disp_cfg.start_y     = start_y_ff;
   assign disp_cfg.filled_code = filled_code_ff;

   bgce_scaler #(
      .KW(KW)
   ) u_scaler (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .level      (req_level),
      .k          (k),
      .full_scale (full_scale_ff),
      .status     (scl_status),
      .q          (q)
   );

   bgce_emitter #(
      .KW    (KW),
      .CELLW (CELLW)
   ) u_emitter (
      .clock         (clock),
      .reset         (reset),
      .go            (scl_status.done),
      .q             (q),
      .cfg           (disp_cfg),
      .busy          (emit_busy),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_is_cursor (rsp_is_cursor),
      .rsp_column    (rsp_column),
      .rsp_row       (rsp_row),
      .rsp_char_code (rsp_char_code),
      .rsp_last      (rsp_last)
   );

endmodule
